// File: rtl/w2s_pkg.sv
// Package for the world-to-screen projector: payload structs, opcodes and register indexes.
// No dependencies; used by world_to_screen_projector and its testbench.
`timescale 1ns / 1ps
package w2s_pkg;
	localparam logic OP_LOAD = 1'b0;
	localparam logic OP_PROJECT = 1'b1;

	localparam logic [1:0] REG_LAYOUT = 2'd0;
	localparam logic [1:0] REG_WIDTH = 2'd1;
	localparam logic [1:0] REG_HEIGHT = 2'd2;

	localparam int CFG_W = 15;

	typedef struct packed {
		logic opcode;
		logic [3:0] coef_index;
		logic signed [31:0] coef_value;
		logic signed [31:0] pos_x;
		logic signed [31:0] pos_y;
		logic signed [31:0] pos_z;
	} in_item_t;

	typedef struct packed {
		logic signed [31:0] screen_x;
		logic signed [31:0] screen_y;
		logic visible;
	} out_item_t;
endpackage

// File: rtl/world_to_screen_projector.sv
// World-to-screen projector top level: coefficient store, sequencer, one shared
// 33x32 multiplier and a bit-serial divider. Depends on w2s_pkg.
// Sequence: a load item is stored at the edge that accepts it; a project item computes the
// three rows, then two divisions (set-up, bit-serial loop, write-back), then scales x and y;
// an invisible point presents its result as soon as its w row is known.
// A new item is not accepted until the block is idle and its last result has been taken.
// Reset (arst_n low) clears control state and restores layout 0, 1920 x 1080; the
// coefficient store is not cleared.
`timescale 1ns / 1ps
module world_to_screen_projector #(
	parameter int FRAC_BITS = 16
) (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_stall,
	input  w2s_pkg::in_item_t in_item,
	output logic out_valid,
	input  logic out_stall,
	output w2s_pkg::out_item_t out_item,
	input  logic cfg_we,
	input  logic [1:0] cfg_index,
	input  logic [w2s_pkg::CFG_W-1:0] cfg_data
);
	import w2s_pkg::*;

	localparam logic signed [33:0] W_MIN = 34'((64'd1 << FRAC_BITS) + 64'd5) / 34'd10;
	localparam logic signed [63:0] S_MAX = 64'sd2147483647;
	localparam logic signed [63:0] S_MIN = -64'sd2147483648;
	localparam int DIV_W = 32 + FRAC_BITS;

	// Sequencer states, one-hot.
	typedef enum logic [8:0] {
		ST_IDLE = 9'b0_0000_0001,
		ST_MUL  = 9'b0_0000_0010,
		ST_ACC  = 9'b0_0000_0100,
		ST_ROW  = 9'b0_0000_1000,
		ST_DIV  = 9'b0_0001_0000,
		ST_SCL  = 9'b0_0010_0000,
		ST_SCLW = 9'b0_0100_0000,
		ST_OUT  = 9'b0_1000_0000,
		ST_FIN  = 9'b1_0000_0000
	} state_t;

	state_t state_q;
	logic layout_q;
	logic [CFG_W-1:0] width_q, height_q;
	logic signed [31:0] coef_mem [16];
	logic signed [31:0] px_q, py_q, pz_q;
	logic [1:0] row_q;      // 0 x, 1 y, 2 w
	logic [1:0] col_q;      // column 0..3
	logic signed [63:0] prod_q;
	logic signed [65:0] acc_q;
	logic signed [31:0] cx_q, cy_q, cw_q;
	logic div_sel_q;        // 0 dividing x, 1 dividing y
	logic [5:0] div_cnt_q;
	logic [DIV_W-1:0] quo_q;
	logic [32:0] rem_q;
	logic [DIV_W-1:0] dvd_q;
	logic neg_q;
	logic signed [31:0] nx_q, ny_q;
	logic scl_sel_q;
	out_item_t res_q;
	logic out_valid_q;

	// Coefficient slot from row and column, per layout.
	logic [1:0] mrow;
	logic [3:0] slot;
	logic signed [31:0] coef_rd;
	logic signed [32:0] mul_a;
	logic signed [31:0] mul_b;
	assign mrow = (row_q == 2'd2) ? 2'd3 : row_q;
	assign slot = layout_q ? {mrow, col_q} : {col_q, mrow};
	assign coef_rd = coef_mem[slot];

	// The scaling operand 1 + x/w or 1 - y/w can exceed 32 bits, hence one extra bit.
	always_comb begin
		unique case (col_q)
			2'd0: mul_a = 33'(px_q);
			2'd1: mul_a = 33'(py_q);
			default: mul_a = 33'(pz_q);
		endcase
		mul_b = coef_rd;
		if (state_q == ST_SCL) begin
			mul_a = scl_sel_q ? (33'sd1 <<< FRAC_BITS) - 33'(ny_q) :
				(33'sd1 <<< FRAC_BITS) + 33'(nx_q);
			mul_b = 32'($signed({1'b0, scl_sel_q ? height_q : width_q}));
		end
	end

	// Dot product: the full products are summed, then the sum is floor-shifted and the translation added.
	logic signed [65:0] acc_sh;
	logic signed [65:0] row_sum;
	logic signed [31:0] row_sat;
	assign acc_sh = acc_q >>> FRAC_BITS;
	assign row_sum = acc_sh + 66'(coef_rd);
	assign row_sat = (row_sum > 66'(S_MAX)) ? 32'(S_MAX) :
		(row_sum < 66'(S_MIN)) ? 32'(S_MIN) : row_sum[31:0];

	// Serial restoring divider on magnitudes.
	logic [31:0] w_mag;
	logic [32:0] rem_try;
	logic [DIV_W:0] quo_mag;
	logic signed [DIV_W+1:0] quo_s;
	logic signed [31:0] quo_sat;
	assign w_mag = cw_q;
	assign rem_try = {rem_q[31:0], dvd_q[DIV_W-1]};
	assign quo_mag = {1'b0, quo_q};
	assign quo_s = neg_q ? -$signed({1'b0, quo_mag}) : $signed({1'b0, quo_mag});
	assign quo_sat = (quo_s > (DIV_W+2)'(S_MAX)) ? 32'(S_MAX) :
		(quo_s < (DIV_W+2)'(S_MIN)) ? 32'(S_MIN) : quo_s[31:0];

	logic signed [31:0] num_sel;
	logic [31:0] num_mag;
	assign num_sel = div_sel_q ? cy_q : cx_q;
	assign num_mag = num_sel[31] ? 32'(-num_sel) : num_sel;

	logic signed [63:0] scl_sh;
	logic signed [31:0] scl_sat;
	assign scl_sh = prod_q >>> 1;
	assign scl_sat = (scl_sh > S_MAX) ? 32'(S_MAX) : (scl_sh < S_MIN) ? 32'(S_MIN) : scl_sh[31:0];

	assign in_stall = (state_q != ST_IDLE) || out_valid_q;
	assign out_valid = out_valid_q;
	assign out_item = res_q;

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall && in_item.opcode == OP_LOAD) begin
			coef_mem[in_item.coef_index] <= in_item.coef_value;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			out_valid_q <= 1'b0;
			layout_q <= 1'b0;
			width_q <= CFG_W'(1920);
			height_q <= CFG_W'(1080);
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					REG_LAYOUT: layout_q <= cfg_data[0];
					REG_WIDTH: width_q <= cfg_data;
					REG_HEIGHT: height_q <= cfg_data;
					default: ;
				endcase
			end
			if (out_valid_q && !out_stall) out_valid_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid && !in_stall && in_item.opcode == OP_PROJECT) begin
						px_q <= in_item.pos_x;
						py_q <= in_item.pos_y;
						pz_q <= in_item.pos_z;
						row_q <= 2'd0;
						col_q <= 2'd0;
						acc_q <= '0;
						state_q <= ST_MUL;
					end
				end
				ST_MUL: begin
					prod_q <= 64'(mul_a) * 64'(mul_b);
					state_q <= ST_ACC;
				end
				ST_ACC: begin
					acc_q <= acc_q + 66'(prod_q);
					if (col_q == 2'd2) begin
						col_q <= 2'd3;
						state_q <= ST_ROW;
					end else begin
						col_q <= col_q + 2'd1;
						state_q <= ST_MUL;
					end
				end
				ST_ROW: begin
					unique case (row_q)
						2'd0: cx_q <= row_sat;
						2'd1: cy_q <= row_sat;
						default: cw_q <= row_sat;
					endcase
					acc_q <= '0;
					col_q <= 2'd0;
					if (row_q == 2'd2) begin
						if ($signed({{2{row_sat[31]}}, row_sat}) < W_MIN) begin
							res_q <= '0;
							out_valid_q <= 1'b1;
							state_q <= ST_IDLE;
						end else begin
							div_sel_q <= 1'b0;
							div_cnt_q <= 6'd0;
							state_q <= ST_OUT;
						end
					end else begin
						row_q <= row_q + 2'd1;
						state_q <= ST_MUL;
					end
				end
				ST_OUT: begin
					// Division set-up for the numerator selected by div_sel_q.
					dvd_q <= {num_mag, FRAC_BITS'(0)};
					neg_q <= num_sel[31];
					rem_q <= '0;
					quo_q <= '0;
					div_cnt_q <= 6'd0;
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					dvd_q <= dvd_q << 1;
					if (rem_try >= {1'b0, w_mag}) begin
						rem_q <= rem_try - {1'b0, w_mag};
						quo_q <= {quo_q[DIV_W-2:0], 1'b1};
					end else begin
						rem_q <= rem_try;
						quo_q <= {quo_q[DIV_W-2:0], 1'b0};
					end
					if (div_cnt_q == 6'(DIV_W - 1)) state_q <= ST_SCLW;
					div_cnt_q <= div_cnt_q + 6'd1;
				end
				ST_SCLW: begin
					if (!div_sel_q) begin
						nx_q <= quo_sat;
						div_sel_q <= 1'b1;
						state_q <= ST_OUT;
					end else begin
						ny_q <= quo_sat;
						scl_sel_q <= 1'b0;
						state_q <= ST_SCL;
					end
				end
				ST_SCL: begin
					// First pass scales x; the second takes the x product and scales y.
					prod_q <= 64'(mul_a) * 64'(mul_b);
					scl_sel_q <= 1'b1;
					if (scl_sel_q) begin
						res_q.screen_x <= scl_sat;
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					res_q.screen_y <= scl_sat;
					res_q.visible <= 1'b1;
					out_valid_q <= 1'b1;
					state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

`ifndef SYNTHESIS
	a_state_onehot: assert property (@(posedge clk) disable iff (!arst_n) $onehot(state_q));
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_item));
	a_busy_stalls: assert property (@(posedge clk) disable iff (!arst_n)
		state_q != ST_IDLE |-> in_stall);
	a_result_idle: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> state_q == ST_IDLE);
	a_hidden_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_item.visible |-> out_item.screen_x == '0 && out_item.screen_y == '0);
`endif
endmodule

// File: tb/world_to_screen_projector_test.sv
// Self-checking testbench for world_to_screen_projector: matrix loads, projections,
// layout and viewport settings, with random idling on both sides. Depends on w2s_pkg.
`timescale 1ns / 1ps

class projection_scoreboard;
	// Predictor state: coefficient store and register copies.
	logic [31:0] coefs[16];
	bit layout_row_major;
	logic [14:0] vp_width;
	logic [14:0] vp_height;
	w2s_pkg::out_item_t pending_points[$];
	int fail_count;

	function void reset_state();
		foreach (coefs[i]) coefs[i] = '0;
		layout_row_major = 0;
		vp_width = 15'd1920;
		vp_height = 15'd1080;
		pending_points.delete();
	endfunction

	function longint floor_half(longint v, int s);
		return v >>> s;
	endfunction

	function longint sat32(longint v);
		if (v > 64'sd2147483647) return 64'sd2147483647;
		if (v < -64'sd2147483648) return -64'sd2147483648;
		return v;
	endfunction

	function longint coef_of(int row, int col);
		int slot;
		slot = layout_row_major ? row * 4 + col : col * 4 + row;
		return longint'($signed(coefs[slot]));
	endfunction

	function longint clip_value(int row, longint px, longint py, longint pz);
		longint acc;
		// The three products fit in 64 bits each; summing them floor-shifted with
		// carried fraction equals floor of the exact sum.
		longint p0, p1, p2;
		p0 = px * coef_of(row, 0);
		p1 = py * coef_of(row, 1);
		p2 = pz * coef_of(row, 2);
		acc = (p0 >>> 16) + (p1 >>> 16) + (p2 >>> 16)
			+ (((p0 & 64'shFFFF) + (p1 & 64'shFFFF) + (p2 & 64'shFFFF)) >>> 16);
		return sat32(acc + coef_of(row, 3));
	endfunction

	function void note_item(w2s_pkg::in_item_t it);
		w2s_pkg::out_item_t res;
		longint px, py, pz, cx, cy, cw, nx, ny;
		if (it.opcode == w2s_pkg::OP_LOAD) begin
			coefs[it.coef_index] = it.coef_value;
			return;
		end
		px = it.pos_x;
		py = it.pos_y;
		pz = it.pos_z;
		cx = clip_value(0, px, py, pz);
		cy = clip_value(1, px, py, pz);
		cw = clip_value(3, px, py, pz);
		res = '0;
		if (cw >= 6554) begin
			nx = sat32((cx * 65536) / cw);
			ny = sat32((cy * 65536) / cw);
			res.screen_x = 32'(sat32(floor_half(longint'(vp_width) * (65536 + nx), 1)));
			res.screen_y = 32'(sat32(floor_half(longint'(vp_height) * (65536 - ny), 1)));
			res.visible = 1'b1;
		end
		pending_points.push_back(res);
	endfunction

	function void check_result(w2s_pkg::out_item_t got);
		w2s_pkg::out_item_t exp_res;
		if (pending_points.size() == 0) begin
			$display("%0t: unexpected result, expected none, actual %h", $time, got);
			fail_count++;
			return;
		end
		exp_res = pending_points.pop_front();
		if (got.screen_x !== exp_res.screen_x) begin
			$display("%0t: screen_x expected %0d actual %0d", $time,
				exp_res.screen_x, got.screen_x);
			fail_count++;
		end
		if (got.screen_y !== exp_res.screen_y) begin
			$display("%0t: screen_y expected %0d actual %0d", $time,
				exp_res.screen_y, got.screen_y);
			fail_count++;
		end
		if (got.visible !== exp_res.visible) begin
			$display("%0t: visible expected %0d actual %0d", $time,
				exp_res.visible, got.visible);
			fail_count++;
		end
	endfunction
endclass

module world_to_screen_projector_test;
	import w2s_pkg::*;

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_stall;
	in_item_t in_item;
	logic out_valid;
	logic out_stall;
	out_item_t out_item;
	logic cfg_we;
	logic [1:0] cfg_index;
	logic [CFG_W-1:0] cfg_data;

	projection_scoreboard board;
	bit sink_enabled;

	world_to_screen_projector uut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_item(in_item),
		.out_valid(out_valid), .out_stall(out_stall), .out_item(out_item),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Safety net: the slowest correct run is well under this.
	initial begin
		#50_000_000;
		$display("[FAIL] regression broken");
		$finish;
	end

	// Gap length: mostly zero or short, now and then a long one.
	function automatic int gap_length();
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 50) return 0;
		if (roll < 92) return $urandom_range(1, 4);
		return $urandom_range(20, 120);
	endfunction

	// Random 32-bit value biased towards the extremes and small magnitudes.
	function automatic logic [31:0] pick_word();
		case ($urandom_range(0, 7))
			0: return 32'h7FFF_FFFF;
			1: return 32'h8000_0000;
			2: return $urandom_range(0, 1) ? 32'h0001_0000 : 32'hFFFF_0000;
			3, 4: return $signed($urandom_range(0, 32'h0040_0000)) - 32'sh0020_0000;
			default: return $urandom;
		endcase
	endfunction

	// Random filler for every field of an input item.
	function automatic in_item_t random_item();
		logic [191:0] fill;
		fill = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
		return fill[$bits(in_item_t)-1:0];
	endfunction

	// Result side: random stall, each accepted result is checked at the edge.
	initial begin
		int hold;
		out_stall = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (out_valid && !out_stall) board.check_result(out_item);
			if (hold > 0) begin
				hold--;
				out_stall <= 1'b1;
			end else begin
				hold = sink_enabled ? gap_length() : 0;
				out_stall <= hold > 0;
			end
		end
	end

	// Present one item and hold it until it is taken, then an idle gap.
	task automatic send_item(in_item_t it);
		int gap;
		in_item <= it;
		in_valid <= 1'b1;
		do @(posedge clk); while (in_stall);
		board.note_item(it);
		gap = gap_length();
		if (gap > 0) begin
			in_valid <= 1'b0;
			in_item <= random_item();
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic load_coef(int slot, logic [31:0] value);
		in_item_t it;
		it = random_item();
		it.opcode = OP_LOAD;
		it.coef_index = 4'(slot);
		it.coef_value = value;
		send_item(it);
	endtask

	task automatic project_point(logic [31:0] x, logic [31:0] y, logic [31:0] z);
		in_item_t it;
		it = random_item();
		it.opcode = OP_PROJECT;
		it.pos_x = x;
		it.pos_y = y;
		it.pos_z = z;
		send_item(it);
	endtask

	// Let every expected result arrive, then keep clocking with no input, so that a
	// register write finds it idle.
	task automatic drain();
		int guard;
		in_valid <= 1'b0;
		guard = 0;
		while (board.pending_points.size() != 0 && guard < 200_000) begin
			@(posedge clk);
			guard++;
		end
		repeat (120) @(posedge clk);
	endtask

	task automatic write_reg(logic [1:0] idx, logic [CFG_W-1:0] value);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == REG_LAYOUT) board.layout_row_major = value[0];
		else if (idx == REG_WIDTH) board.vp_width = value;
		else if (idx == REG_HEIGHT) board.vp_height = value;
	endtask

	// A plausible camera: random coefficients in -1.0..1.0, now and then an extreme one,
	// and a positive w row translation so that most points are in front.
	task automatic load_camera();
		for (int s = 0; s < 16; s++) begin
			logic [31:0] v;
			v = $signed($urandom_range(0, 32'h0002_0000)) - 32'sh0001_0000;
			if ($urandom_range(0, 9) == 0) v = pick_word();
			load_coef(s, v);
		end
		// Translation of the w row pushed positive so projections are mostly visible.
		load_coef(board.layout_row_major ? 15 : 15, 32'h000A_0000 + $urandom_range(0, 32'hF_FFFF));
	endtask

	initial begin
		logic [14:0] sizes[6];
		board = new();
		board.reset_state();
		sink_enabled = 1'b1;
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_item = '0;
		cfg_we = 1'b0;
		cfg_index = REG_LAYOUT;
		cfg_data = '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: identity matrix with reset viewport, then the corner cases.
		for (int s = 0; s < 16; s++)
			load_coef(s, (s % 5 == 0) ? 32'h0001_0000 : 32'h0);
		project_point(32'h0, 32'h0, 32'h0);                  // w exactly 1.0
		project_point(32'h0000_8000, 32'hFFFF_8000, 32'h1234);
		project_point(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
		load_coef(15, 32'd6553);                             // w just under 0.1
		project_point(32'h0001_0000, 32'h0001_0000, 32'h0);
		load_coef(15, 32'd6554);                             // w exactly at 0.1
		project_point(32'h0001_0000, 32'hFFFF_0000, 32'h0);
		load_coef(15, 32'h8000_0000);                        // very negative w
		project_point(32'h0, 32'h0, 32'h0);
		load_coef(15, 32'h0001_0000);
		drain();

		// Extreme registers: layout 1, smallest, largest and zero sizes.
		write_reg(REG_LAYOUT, CFG_W'(1));
		write_reg(REG_WIDTH, CFG_W'(1));
		write_reg(REG_HEIGHT, CFG_W'(16384));
		project_point(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000);
		project_point(32'h0000_4000, 32'h0000_C000, 32'h0);
		drain();
		write_reg(REG_WIDTH, CFG_W'(0));
		write_reg(REG_HEIGHT, 15'h7FFF);
		project_point(32'h0000_4000, 32'h0000_C000, 32'h0);
		drain();

		// Random phases, each with its own settings and a freshly loaded matrix.
		sizes = '{15'd1, 15'd16384, 15'd1920, 15'd1080, 15'd640, 15'h7FFF};
		for (int phase = 0; phase < 16; phase++) begin
			write_reg(REG_LAYOUT, CFG_W'($urandom_range(0, 1)));
			write_reg(REG_WIDTH, CFG_W'($urandom_range(0, 2) == 0 ?
				sizes[$urandom_range(0, 5)] : $urandom_range(1, 16384)));
			write_reg(REG_HEIGHT, CFG_W'($urandom_range(0, 2) == 0 ?
				sizes[$urandom_range(0, 5)] : $urandom_range(1, 16384)));
			sink_enabled = phase % 4 != 3;
			load_camera();
			for (int n = 0; n < 80; n++) begin
				if ($urandom_range(0, 9) == 0)
					load_coef($urandom_range(0, 15), pick_word());
				else
					project_point(pick_word(), pick_word(), pick_word());
			end
			drain();
		end

		sink_enabled = 1'b1;
		drain();
		if (board.fail_count == 0 && board.pending_points.size() == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end
endmodule

// File: sim.f
rtl/w2s_pkg.sv
rtl/world_to_screen_projector.sv
tb/world_to_screen_projector_test.sv
